// ===== src/cmrs_pkg.sv =====
package cmrs_pkg;

  // Default build
  localparam int DefCoordBits = 16;
  localparam int DefFracBits  = 16;

  // Fixed field widths
  localparam int TimeStepW = 16;
  localparam int SpeedW    = 16;
  localparam int OutW      = 18;
  localparam int CfgIdxW   = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPoint0    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPoint1    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPoint2    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPoint3    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeed     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRunEnable = 3'd5;

  // Axis selects
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // Polynomial coefficient selects
  localparam logic [1:0] CoefA0 = 2'd0;
  localparam logic [1:0] CoefA1 = 2'd1;
  localparam logic [1:0] CoefA2 = 2'd2;
  localparam logic [1:0] CoefA3 = 2'd3;

  typedef struct packed {
    logic       accept;    // capture the time step beat
    logic       advance;   // clamp and advance the parameter
    logic       init;      // capture t, load the cubic coefficient
    logic       mul;       // multiply accumulator by t
    logic       acc;       // round product, add next coefficient
    logic       store;     // round, saturate and keep one coordinate
    logic       load_out;  // move the finished point to the output register
    logic [1:0] axis;
    logic [1:0] coef;
  } cmrs_cmd_t;

endpackage

// ===== src/catmull_rom_path_stepper.sv =====
// Catmull-Rom path stepper: each time_step beat on the slave stream advances
// the segment parameter (when run_enable is set) by time_step * travel_speed,
// then evaluates the uniform Catmull-Rom segment from P1 to P2 at
// min(parameter, 1.0) and sends one beat with x, y, z, the parameter used and
// the done flag. Items are handled one at a time: the next item is taken only
// after the previous one has been moved into the output register, and that
// move waits while the master side stalls. The idle state takes the beat, then
// the parameter advances, then each axis gets the Horner evaluation on a
// single shared multiplier (coefficient load, three multiply and
// round-accumulate pairs, round and saturate), then the result moves into the output
// register. A waiting result beat does not block the next item; a second
// result waits until the first has been taken.
// Configuration writes are taken on any cycle with cfg_we_i high and must
// only come while the block is idle.
module catmull_rom_path_stepper
  import cmrs_pkg::*;
#(
  parameter int COORD_BITS = DefCoordBits,
  parameter int FRAC_BITS  = DefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [3*COORD_BITS-1:0]       cfg_data_i,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [TimeStepW-1:0]          s_axis_tdata,  // time_step
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, param_used, path_done, zero pad
  output logic [((3*OutW+FRAC_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OutTdW = ((3 * OutW + FRAC_BITS + 2 + 7) / 8) * 8;

  cmrs_cmd_t              cmd;
  logic signed [OutW-1:0] pos_x, pos_y, pos_z;
  logic [FRAC_BITS:0]     param_used;
  logic                   path_done;

  cmrs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  cmrs_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .time_step_i  (s_axis_tdata),
    .cmd_i        (cmd),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .pos_z_o      (pos_z),
    .param_used_o (param_used),
    .path_done_o  (path_done)
  );

  assign m_axis_tdata = OutTdW'({path_done, param_used, pos_z, pos_y, pos_x});

endmodule

// ===== src/cmrs_ctrl.sv =====
module cmrs_ctrl
  import cmrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output cmrs_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_INIT,
    S_MUL,
    S_ACC,
    S_STORE,
    S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] axis_q;
  logic [1:0] coef_q;
  logic       m_valid_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = s_axis_tvalid && (state_q == S_IDLE);
    cmd_o.advance  = (state_q == S_ADV);
    cmd_o.init     = (state_q == S_INIT);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.acc      = (state_q == S_ACC);
    cmd_o.store    = (state_q == S_STORE);
    cmd_o.load_out = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
    cmd_o.axis     = axis_q;
    cmd_o.coef     = (state_q == S_INIT) ? CoefA3 : coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      axis_q    <= AxisX;
      coef_q    <= CoefA2;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          axis_q  <= AxisX;
          state_q <= S_INIT;
        end
        S_INIT: begin
          coef_q  <= CoefA2;
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (coef_q == CoefA0) begin
            state_q <= S_STORE;
          end else begin
            coef_q  <= coef_q - 2'd1;
            state_q <= S_MUL;
          end
        end
        S_STORE: begin
          if (axis_q == AxisZ) begin
            state_q <= S_OUT;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_INIT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten while a beat waits");

  a_accept_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_ADV))
    else $error("accepted beat did not start an advance");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (axis_q != 2'd3))
    else $error("axis counter out of range");

  a_coef_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (coef_q != CoefA3))
    else $error("outer coefficient reused in accumulate step");

endmodule

// ===== src/cmrs_datapath.sv =====
module cmrs_datapath
  import cmrs_pkg::*;
#(
  parameter int COORD_BITS = DefCoordBits,
  parameter int FRAC_BITS  = DefFracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [3*COORD_BITS-1:0]     cfg_data_i,
  input  logic [TimeStepW-1:0]        time_step_i,
  input  cmrs_cmd_t                   cmd_i,
  output logic signed [OutW-1:0]      pos_x_o,
  output logic signed [OutW-1:0]      pos_y_o,
  output logic signed [OutW-1:0]      pos_z_o,
  output logic [FRAC_BITS:0]          param_used_o,
  output logic                        path_done_o
);

  localparam int C     = COORD_BITS;
  localparam int PtW   = 3 * C;
  localparam int PW    = FRAC_BITS + 2;
  localparam int SpdPW = TimeStepW + SpeedW;
  localparam int IncW  = SpdPW - (24 - FRAC_BITS);
  localparam int SumW  = ((IncW > PW) ? IncW : PW) + 1;
  localparam int SW    = C + 6;
  localparam int PRW   = SW + FRAC_BITS + 2;
  localparam int EW    = (SW > OutW) ? SW : OutW;

  localparam logic [PW-1:0]          ParamOne = PW'(1) << FRAC_BITS;
  localparam logic [SumW-1:0]        ParamMax = SumW'({PW{1'b1}});
  localparam logic signed [PRW-1:0]  PrHalf   = PRW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0]   SatHi    = EW'(2 ** (OutW - 1) - 1);
  localparam logic signed [EW-1:0]   SatLo    = -SatHi - EW'(1);

  logic [PtW-1:0]    pt_q [4];
  logic [SpeedW-1:0] speed_q;
  logic              run_en_q;
  logic [PW-1:0]     param_q;
  logic              done_q;

  logic [SpdPW-1:0]         spd_prod_q;
  logic [FRAC_BITS:0]       t_q;
  logic signed [SW-1:0]     s_q;
  logic signed [PRW-1:0]    mprod_q;
  logic signed [OutW-1:0]   pos_q [3];

  logic signed [OutW-1:0]   out_x_q, out_y_q, out_z_q;
  logic [FRAC_BITS:0]       out_t_q;
  logic                     out_done_q;

  // Parameter advance
  logic [PW-1:0]   base;
  logic [IncW-1:0] inc;
  logic [SumW-1:0] sum;
  logic [PW-1:0]   param_next;

  assign base       = (param_q >= ParamOne) ? ParamOne : param_q;
  assign inc        = spd_prod_q[SpdPW-1:24-FRAC_BITS];
  assign sum        = SumW'(base) + SumW'(inc);
  assign param_next = (sum > ParamMax) ? {PW{1'b1}} : sum[PW-1:0];

  // Coefficients of the selected axis
  logic signed [SW-1:0] p0, p1, p2, p3;
  logic signed [SW-1:0] a0, a1, a2, a3, coef;

  always_comb begin
    unique case (cmd_i.axis)
      AxisX: begin
        p0 = SW'(signed'(pt_q[0][C-1:0]));
        p1 = SW'(signed'(pt_q[1][C-1:0]));
        p2 = SW'(signed'(pt_q[2][C-1:0]));
        p3 = SW'(signed'(pt_q[3][C-1:0]));
      end
      AxisY: begin
        p0 = SW'(signed'(pt_q[0][2*C-1:C]));
        p1 = SW'(signed'(pt_q[1][2*C-1:C]));
        p2 = SW'(signed'(pt_q[2][2*C-1:C]));
        p3 = SW'(signed'(pt_q[3][2*C-1:C]));
      end
      AxisZ: begin
        p0 = SW'(signed'(pt_q[0][3*C-1:2*C]));
        p1 = SW'(signed'(pt_q[1][3*C-1:2*C]));
        p2 = SW'(signed'(pt_q[2][3*C-1:2*C]));
        p3 = SW'(signed'(pt_q[3][3*C-1:2*C]));
      end
      default: begin
        p0 = '0;
        p1 = '0;
        p2 = '0;
        p3 = '0;
      end
    endcase
  end

  assign a0 = p1 <<< 1;
  assign a1 = p2 - p0;
  assign a2 = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
  assign a3 = ((p1 <<< 1) + p1) - p0 - ((p2 <<< 1) + p2) + p3;

  always_comb begin
    unique case (cmd_i.coef)
      CoefA0:  coef = a0;
      CoefA1:  coef = a1;
      CoefA2:  coef = a2;
      default: coef = a3;
    endcase
  end

  // Round to nearest, ties up: add half then floor
  logic signed [PRW-1:0] prod_rnd;
  logic signed [SW-1:0]  half_s;
  logic signed [EW-1:0]  fin;
  logic signed [OutW-1:0] fin_sat;

  assign prod_rnd = (mprod_q + PrHalf) >>> FRAC_BITS;
  assign half_s   = (s_q + SW'(1)) >>> 1;
  assign fin      = EW'(half_s);
  assign fin_sat  = (fin > SatHi) ? OutW'(SatHi) :
                    (fin < SatLo) ? OutW'(SatLo) : OutW'(fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q[0]  <= '0;
      pt_q[1]  <= '0;
      pt_q[2]  <= '0;
      pt_q[3]  <= '0;
      speed_q  <= '0;
      run_en_q <= 1'b0;
      param_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPoint0:    pt_q[0]  <= cfg_data_i;
          RegPoint1:    pt_q[1]  <= cfg_data_i;
          RegPoint2:    pt_q[2]  <= cfg_data_i;
          RegPoint3:    pt_q[3]  <= cfg_data_i;
          RegSpeed:     speed_q  <= cfg_data_i[SpeedW-1:0];
          RegRunEnable: run_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.advance && run_en_q) begin
        param_q <= param_next;
        if (param_q >= ParamOne) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      spd_prod_q <= SpdPW'(time_step_i) * SpdPW'(speed_q);
    end
    if (cmd_i.init) begin
      t_q <= (param_q > ParamOne) ? ParamOne[FRAC_BITS:0] : param_q[FRAC_BITS:0];
      s_q <= coef;
    end
    if (cmd_i.mul) begin
      mprod_q <= PRW'(s_q) * PRW'(signed'({1'b0, t_q}));
    end
    if (cmd_i.acc) begin
      s_q <= coef + SW'(prod_rnd);
    end
    if (cmd_i.store) begin
      unique case (cmd_i.axis)
        AxisX:   pos_q[0] <= fin_sat;
        AxisY:   pos_q[1] <= fin_sat;
        default: pos_q[2] <= fin_sat;
      endcase
    end
    if (cmd_i.load_out) begin
      out_x_q    <= pos_q[0];
      out_y_q    <= pos_q[1];
      out_z_q    <= pos_q[2];
      out_t_q    <= t_q;
      out_done_q <= done_q;
    end
  end

  assign pos_x_o      = out_x_q;
  assign pos_y_o      = out_y_q;
  assign pos_z_o      = out_z_q;
  assign param_used_o = out_t_q;
  assign path_done_o  = out_done_q;

endmodule
